// File: rtl/core/lpmd_pkg.sv
// Package for the length-prefixed multi-message deframer.
// Holds the parse phase codes and the result word type; no dependencies.
package lpmd_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_LEN_LO   = 4'd0;
  localparam logic [PhaseW-1:0] PH_LEN_HI   = 4'd1;
  localparam logic [PhaseW-1:0] PH_LABEL_LO = 4'd2;
  localparam logic [PhaseW-1:0] PH_LABEL_HI = 4'd3;
  localparam logic [PhaseW-1:0] PH_COUNT    = 4'd4;
  localparam logic [PhaseW-1:0] PH_SUB_LO   = 4'd5;
  localparam logic [PhaseW-1:0] PH_SUB_HI   = 4'd6;
  localparam logic [PhaseW-1:0] PH_PAYLOAD  = 4'd7;
  localparam logic [PhaseW-1:0] PH_DISCARD  = 4'd8;

  localparam logic [15:0] SingleLabelReset = 16'd24;
  localparam logic [16:0] SubHdrBytes      = 17'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
    logic       empty_message;
  } res_t;

endpackage

// File: rtl/core/length_prefixed_multi_message_deframer_core.sv
// Length-prefixed multi-message deframer, top level.
// Depends on lpmd_pkg for phase codes and the result word type.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one word, a byte
//   of the received stream, per accepted edge. Each frame is a 16-bit
//   little-endian length L, then a body of L+2 bytes opening with a 16-bit
//   label. A label equal to the single_label register delivers the L bytes
//   after it as one message; any other label opens a bundle: a count byte,
//   then that many sub-messages, each a 16-bit length and its payload.
//   Output channel (out_valid_o / out_stall_i) carries at most one result
//   word per input word: a message byte with first/last marks, or one
//   empty-message word for a zero-length message.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes single_label;
//   write it only while the block is idle. cfg_ready_o is always high.
// Timing:
//   One input word per clock cycle while in_stall_o is low. A result is
//   registered in the result register, or in the skid while that is held;
//   the parser state updates on each accepted word. A two-entry output buffer
//   (result register plus skid) keeps input flowing while the receiver stalls;
//   in_stall_o rises only once both are full. Reset clears the parser to
//   expect a length low byte, empties the buffer and sets single_label to 24.
module length_prefixed_multi_message_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       first_of_message_o,
  output logic       last_of_message_o,
  output logic       empty_message_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [15:0] cfg_single_label_i
);

  logic [15:0] single_label_q;

  logic [lpmd_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [16:0] body_left_q, body_left_d;
  logic [7:0]  held_low_byte_q, held_low_byte_d;
  logic [7:0]  messages_left_q, messages_left_d;
  logic [15:0] message_left_q, message_left_d;
  logic        message_started_q, message_started_d;

  logic           in_fire;
  logic           res_valid;
  lpmd_pkg::res_t res;
  logic [15:0]    word16;

  logic           main_valid_q, skid_valid_q;
  lpmd_pkg::res_t main_q, skid_q;
  logic           out_fire;

  // Pick what follows a message end or the count byte.
  function automatic logic [lpmd_pkg::PhaseW-1:0] next_sub(
    input logic [16:0] bl,
    input logic [7:0]  msgs
  );
    logic [lpmd_pkg::PhaseW-1:0] ph;
    if (bl == 17'd0) begin
      ph = lpmd_pkg::PH_LEN_LO;
    end else if (msgs == 8'd0 || bl < lpmd_pkg::SubHdrBytes) begin
      ph = lpmd_pkg::PH_DISCARD;
    end else begin
      ph = lpmd_pkg::PH_SUB_LO;
    end
    return ph;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign word16      = {rx_byte_i, held_low_byte_q};

  // Parser: one byte per cycle while in_stall_o is low, all decisions in one pass.
  always_comb begin
    phase_d           = phase_q;
    frame_length_d    = frame_length_q;
    body_left_d       = body_left_q;
    held_low_byte_d   = held_low_byte_q;
    messages_left_d   = messages_left_q;
    message_left_d    = message_left_q;
    message_started_d = message_started_q;
    res_valid         = 1'b0;
    res               = '0;

    if (phase_q == lpmd_pkg::PH_LEN_HI) begin
      frame_length_d = word16;
      body_left_d    = {1'b0, word16} + lpmd_pkg::SubHdrBytes;
      phase_d        = lpmd_pkg::PH_LABEL_LO;
    end else if (phase_q < lpmd_pkg::PH_LABEL_LO || phase_q > lpmd_pkg::PH_DISCARD) begin
      held_low_byte_d = rx_byte_i;
      phase_d         = lpmd_pkg::PH_LEN_HI;
    end else begin
      // Count down the body.
      if (body_left_q != 17'd0) begin
        body_left_d = body_left_q - 17'd1;
      end
      case (phase_q)
        lpmd_pkg::PH_LABEL_LO: begin
          held_low_byte_d = rx_byte_i;
          phase_d         = lpmd_pkg::PH_LABEL_HI;
        end
        lpmd_pkg::PH_LABEL_HI: begin
          if (word16 == single_label_q) begin
            messages_left_d = 8'd0;
            if (frame_length_q == 16'd0) begin
              res_valid = 1'b1;
              res       = '{payload_byte: 8'd0, first_of_message: 1'b1,
                            last_of_message: 1'b1, empty_message: 1'b1};
              phase_d   = next_sub(body_left_d, 8'd0);
            end else begin
              message_left_d    = frame_length_q;
              message_started_d = 1'b0;
              phase_d           = lpmd_pkg::PH_PAYLOAD;
            end
          end else begin
            phase_d = lpmd_pkg::PH_COUNT;
          end
        end
        lpmd_pkg::PH_COUNT: begin
          messages_left_d = rx_byte_i;
          phase_d         = next_sub(body_left_d, rx_byte_i);
        end
        lpmd_pkg::PH_SUB_LO: begin
          held_low_byte_d = rx_byte_i;
          phase_d         = lpmd_pkg::PH_SUB_HI;
        end
        lpmd_pkg::PH_SUB_HI: begin
          if ({1'b0, word16} > body_left_d) begin
            phase_d = lpmd_pkg::PH_DISCARD;
          end else begin
            messages_left_d = messages_left_q - 8'd1;
            if (word16 == 16'd0) begin
              res_valid = 1'b1;
              res       = '{payload_byte: 8'd0, first_of_message: 1'b1,
                            last_of_message: 1'b1, empty_message: 1'b1};
              phase_d   = next_sub(body_left_d, messages_left_d);
            end else begin
              message_left_d    = word16;
              message_started_d = 1'b0;
              phase_d           = lpmd_pkg::PH_PAYLOAD;
            end
          end
        end
        lpmd_pkg::PH_PAYLOAD: begin
          if (message_left_q != 16'd0) begin
            message_left_d = message_left_q - 16'd1;
          end
          res_valid         = 1'b1;
          res               = '{payload_byte: rx_byte_i,
                                first_of_message: !message_started_q,
                                last_of_message: (message_left_d == 16'd0),
                                empty_message: 1'b0};
          message_started_d = 1'b1;
          if (message_left_d == 16'd0) begin
            phase_d = next_sub(body_left_d, messages_left_q);
          end
        end
        default: begin
          // Discard: drop body bytes.
        end
      endcase
      // Body done: expect the next frame.
      if (body_left_d == 17'd0) begin
        phase_d = lpmd_pkg::PH_LEN_LO;
      end
    end

    if (!in_fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_label_q    <= lpmd_pkg::SingleLabelReset;
      phase_q           <= lpmd_pkg::PH_LEN_LO;
      frame_length_q    <= '0;
      body_left_q       <= '0;
      held_low_byte_q   <= '0;
      messages_left_q   <= '0;
      message_left_q    <= '0;
      message_started_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        single_label_q <= cfg_single_label_i;
      end
      if (in_fire) begin
        phase_q           <= phase_d;
        frame_length_q    <= frame_length_d;
        body_left_q       <= body_left_d;
        held_low_byte_q   <= held_low_byte_d;
        messages_left_q   <= messages_left_d;
        message_left_q    <= message_left_d;
        message_started_q <= message_started_d;
      end
    end
  end

  // Output buffer: result register in front, skid behind it.
  assign out_fire = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_fire) begin
      // Advance: the skid word moves up first to keep order.
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        main_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      // Hold the front word; park the new one.
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = main_valid_q;
  assign payload_byte_o     = main_q.payload_byte;
  assign first_of_message_o = main_q.first_of_message;
  assign last_of_message_o  = main_q.last_of_message;
  assign empty_message_o    = main_q.empty_message;

endmodule
